FILE: src/ffd_pkg.sv
// Shared types and constants of the Fletcher frame deframer.
package ffd_pkg;

  localparam logic [7:0] HEADER_RESET = 8'hF9;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CKA  = 3'd3,
    PH_CKB  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      item_kind;
    logic [7:0] frame_length;
  } result_t;

endpackage

FILE: src/ffd_parser.sv
// Frame parser state machine with the running Fletcher sums.
module ffd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       frame_header,
  output logic             res_valid,
  output ffd_pkg::result_t res
);
  import ffd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [7:0] length_seen_r, length_seen_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [7:0] check_a_r, check_a_nxt;
  logic [7:0] sum_a_add;

  assign sum_a_add = sum_a_r + rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      remaining_r   <= '0;
      length_seen_r <= '0;
      sum_a_r       <= '0;
      sum_b_r       <= '0;
      check_a_r     <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      remaining_r   <= remaining_nxt;
      length_seen_r <= length_seen_nxt;
      sum_a_r       <= sum_a_nxt;
      sum_b_r       <= sum_b_nxt;
      check_a_r     <= check_a_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    remaining_nxt   = remaining_r;
    length_seen_nxt = length_seen_r;
    sum_a_nxt       = sum_a_r;
    sum_b_nxt       = sum_b_r;
    check_a_nxt     = check_a_r;
    res_valid       = 1'b0;
    res             = '{data_byte: 8'd0, item_kind: KIND_DATA, frame_length: 8'd0};
    unique case (phase_r)
      PH_LEN: begin
        length_seen_nxt = rx_byte;
        remaining_nxt   = rx_byte;
        sum_a_nxt       = '0;
        sum_b_nxt       = '0;
        phase_nxt       = (rx_byte == 8'd0) ? PH_CKA : PH_DATA;
      end
      PH_DATA: begin
        sum_a_nxt     = sum_a_add;
        sum_b_nxt     = sum_b_r + sum_a_add;
        remaining_nxt = remaining_r - 8'd1;
        if (remaining_r == 8'd1) begin
          phase_nxt = PH_CKA;
        end
        res_valid     = 1'b1;
        res.data_byte = rx_byte;
      end
      PH_CKA: begin
        check_a_nxt = rx_byte;
        phase_nxt   = PH_CKB;
      end
      PH_CKB: begin
        phase_nxt        = PH_HUNT;
        res_valid        = 1'b1;
        res.item_kind    = ((check_a_r == sum_a_r) && (rx_byte == sum_b_r)) ? KIND_OK
                                                                            : KIND_BAD;
        res.frame_length = length_seen_r;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == frame_header) begin
          phase_nxt = PH_LEN;
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end
      end
    endcase
  end

endmodule

FILE: src/ffd_out_reg.sv
// Result register that holds one finished result until it is taken.
module ffd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ffd_pkg::result_t load_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output ffd_pkg::result_t out_data
);
  import ffd_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= load_data;
    end
  end

endmodule

FILE: src/fletcher_frame_deframer_top.sv
// Top level of the length-prefixed frame deframer with a mod-256 Fletcher check.
// Each received byte is taken into an input register and then run through the
// frame parser, whose payload bytes and frame-end results land in an output
// register. A new byte can be taken every cycle while the input register is
// empty or the output register is free, so the block sustains one byte per
// clock unless the output stalls; the parser's state update sets that rate,
// and a stalled output register holds back the input only once both registers
// are full. Write the header byte only while no frame data is in flight.
module fletcher_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_frame_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_frame_header
);
  import ffd_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [7:0] header_r;
  logic       step;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign cfg_ready = 1'b1;
  assign step      = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_r <= cfg_frame_header;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  ffd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (s1_byte_r),
    .frame_header (header_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  ffd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .out_data  (out_data)
  );

  assign out_data_byte    = out_data.data_byte;
  assign out_item_kind    = out_data.item_kind;
  assign out_frame_length = out_data.frame_length;

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r && s1_byte_r == $past(in_rx_byte))
    else $error("accepted byte did not reach the input register");

  a_data_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_DATA |-> out_frame_length == 8'd0)
    else $error("payload result carries a frame length");

  a_end_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind != KIND_DATA |-> out_data_byte == 8'd0)
    else $error("frame-end result carries a data byte");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid |=> out_valid)
    else $error("parser result was lost");
`endif

endmodule

FILE: bench/fletcher_frame_deframer_top_tb.sv
// Self-checking testbench of the mod-256 Fletcher frame deframer with randomized handshakes.
module fletcher_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic [1:0] out_item_kind;
  logic [7:0] out_frame_length;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_frame_header = 8'h00;

  fletcher_frame_deframer_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_item_kind    (out_item_kind),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_header (cfg_frame_header)
  );

  logic [7:0] pending_bytes[$];
  result_t    expected_results[$];
  int         idle_pct = 37;
  int         error_count = 0;
  int         bytes_queued = 0;

  phase_t     parse_phase = PH_HUNT;
  logic [7:0] header_byte = HEADER_RESET;
  logic [7:0] bytes_left = '0;
  logic [7:0] frame_len = '0;
  logic [7:0] fl_sum_a = '0;
  logic [7:0] fl_sum_b = '0;
  logic [7:0] check_a_byte = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic deframe_byte(input logic [7:0] b);
    result_t res;
    res = '{data_byte: 8'h00, item_kind: KIND_DATA, frame_length: 8'h00};
    case (parse_phase)
      PH_LEN: begin
        frame_len = b;
        bytes_left = b;
        fl_sum_a = '0;
        fl_sum_b = '0;
        parse_phase = (b == 8'h00) ? PH_CKA : PH_DATA;
      end
      PH_DATA: begin
        fl_sum_a = fl_sum_a + b;
        fl_sum_b = fl_sum_b + fl_sum_a;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) parse_phase = PH_CKA;
        res.data_byte = b;
        expected_results.push_back(res);
      end
      PH_CKA: begin
        check_a_byte = b;
        parse_phase = PH_CKB;
      end
      PH_CKB: begin
        res.item_kind = (check_a_byte == fl_sum_a && b == fl_sum_b) ? KIND_OK : KIND_BAD;
        res.frame_length = frame_len;
        parse_phase = PH_HUNT;
        expected_results.push_back(res);
      end
      default: begin
        parse_phase = PH_HUNT;
        if (b == header_byte) begin
          parse_phase = PH_LEN;
          fl_sum_a = '0;
          fl_sum_b = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: data_byte %0h item_kind %0d frame_length %0d",
                 out_data_byte, out_item_kind, out_frame_length);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data_byte !== exp_res.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", exp_res.data_byte, out_data_byte);
            error_count++;
          end
          if (out_item_kind !== exp_res.item_kind) begin
            $error("item_kind: expected %0d, actual %0d", exp_res.item_kind, out_item_kind);
            error_count++;
          end
          if (out_frame_length !== exp_res.frame_length) begin
            $error("frame_length: expected %0d, actual %0d",
                   exp_res.frame_length, out_frame_length);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // A frame with cut below len is truncated; the following bytes then land inside it.
  task automatic push_frame(input logic [7:0] hdr, input int len, input int cut,
                            input bit corrupt);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    a = '0;
    b = '0;
    push_byte(hdr);
    push_byte(len[7:0]);
    for (int k = 0; k < len; k++) begin
      if (k >= cut) return;
      d = 8'($urandom_range(255));
      a = a + d;
      b = b + a;
      push_byte(d);
    end
    if (corrupt) begin
      if ($urandom_range(1) == 0) a = a ^ 8'($urandom_range(1, 255));
      else b = b ^ 8'($urandom_range(1, 255));
    end
    push_byte(a);
    push_byte(b);
  endtask

  task automatic wait_inputs_sent();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
  endtask

  // Finish any open frame with zero bytes so the parser is hunting, then let results drain.
  task automatic settle_block();
    wait_inputs_sent();
    while (parse_phase != PH_HUNT) begin
      push_byte(8'h00);
      wait_inputs_sent();
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_frame_header <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    header_byte = v;
  endtask

  task automatic run_random(input int count);
    int r;
    int len;
    int start_count;
    start_count = bytes_queued;
    while (bytes_queued - start_count < count) begin
      r = $urandom_range(99);
      if ($urandom_range(49) == 0) len = $urandom_range(255);
      else len = $urandom_range(12);
      if (r < 70) begin
        push_frame(header_byte, len, len, $urandom_range(99) < 20);
      end else if (r < 85) begin
        push_byte(8'($urandom_range(255)));
      end else begin
        push_frame(header_byte, len, (len == 0) ? 0 : $urandom_range(len - 1), 1'b0);
      end
    end
  endtask

  initial begin
    logic [7:0] directed_bytes[];
    directed_bytes = '{8'h00, 8'hFF,
                       8'hF9, 8'h00, 8'h00, 8'h00,
                       8'hF9, 8'h00, 8'h01, 8'h00,
                       8'hF9, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                       8'hF9, 8'h02, 8'hF9, 8'h80, 8'h79, 8'h73};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
    push_frame(header_byte, 255, 255, 1'b0);
    run_random(210);
    settle_block();

    write_header(8'h00);
    idle_pct = 0;
    run_random(210);
    settle_block();

    write_header(8'hFF);
    idle_pct = 37;
    run_random(210);
    settle_block();

    write_header(8'($urandom_range(255)));
    push_frame(header_byte, 255, 255, 1'b1);
    run_random(210);
    settle_block();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ffd_pkg.sv
src/ffd_parser.sv
src/ffd_out_reg.sv
src/fletcher_frame_deframer_top.sv
bench/fletcher_frame_deframer_top_tb.sv
